/* rtl/sparse_set_component_table_unit_defines.svh */
// Assertion macros shared by the sparse set component table unit.
`ifndef SPARSE_SET_COMPONENT_TABLE_UNIT_DEFINES_SVH
`define SPARSE_SET_COMPONENT_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define SSCT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define SSCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ssct_pkg.sv */
// Types, sizes and codes of the sparse set component table unit.
package ssct_pkg;

  // Sizing
  localparam int ENTITY_SPACE = 1024;
  localparam int CAPACITY     = 256;
  localparam int DATA_WIDTH   = 32;

  localparam int ENT_W   = $clog2(ENTITY_SPACE);
  localparam int SLOT_W  = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int MAP_W   = SLOT_W + 1;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;

  // Stream packing, first field in the lowest bits
  localparam int IN_ENT_LSB  = OP_W;
  localparam int IN_OTH_LSB  = OP_W + ENT_W;
  localparam int IN_DAT_LSB  = OP_W + 2 * ENT_W;
  localparam int IN_W        = OP_W + 2 * ENT_W + DATA_WIDTH;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = STAT_W + DATA_WIDTH + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_GET  = 3'd0;
  localparam logic [OP_W-1:0] OP_SET  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
  localparam logic [OP_W-1:0] OP_COPY = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  // Memory port requests from the sequencer
  typedef struct packed {
    logic                  map_we;
    logic [ENT_W-1:0]      map_waddr;
    logic [MAP_W-1:0]      map_wdata;
    logic [ENT_W-1:0]      map_raddr;
    logic                  data_we;
    logic [SLOT_W-1:0]     data_waddr;
    logic [DATA_WIDTH-1:0] data_wdata;
    logic [SLOT_W-1:0]     data_raddr;
    logic                  own_we;
    logic [SLOT_W-1:0]     own_waddr;
    logic [ENT_W-1:0]      own_wdata;
    logic [SLOT_W-1:0]     own_raddr;
  } mem_req_t;

  // Sequencer status
  typedef struct packed {
    logic clearing;
    logic busy;
  } ctrl_stat_t;

endpackage

/* rtl/ssct_ram.sv */
// Generic synchronous RAM: one write port, one read port, registered read.
module ssct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/ssct_ctrl.sv */
// Sequencer of the sparse set table: lookup, read-modify-write and result register.
module ssct_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ssct_pkg::OP_W-1:0]        in_op,
  input  logic [ssct_pkg::ENT_W-1:0]       in_entity,
  input  logic [ssct_pkg::ENT_W-1:0]       in_other_entity,
  input  logic [ssct_pkg::DATA_WIDTH-1:0]  in_write_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ssct_pkg::STAT_W-1:0]      out_status,
  output logic [ssct_pkg::DATA_WIDTH-1:0]  out_read_data,
  output logic [ssct_pkg::COUNT_W-1:0]     out_live_count,
  output ssct_pkg::mem_req_t               mem_req,
  input  logic [ssct_pkg::MAP_W-1:0]       map_rdata,
  input  logic [ssct_pkg::DATA_WIDTH-1:0]  data_rdata,
  input  logic [ssct_pkg::ENT_W-1:0]       own_rdata,
  output ssct_pkg::ctrl_stat_t             stat
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_LOOK2 = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_DEL   = 4'd5;
  localparam logic [3:0] S_DEL2  = 4'd6;
  localparam logic [3:0] S_RESP  = 4'd7;

  localparam logic [ssct_pkg::ENT_W-1:0] ENT_LAST =
    ssct_pkg::ENT_W'(ssct_pkg::ENTITY_SPACE - 1);
  localparam logic [ssct_pkg::COUNT_W-1:0] CNT_FULL =
    ssct_pkg::COUNT_W'(ssct_pkg::CAPACITY);

  logic [3:0]                        state_r, state_nxt;
  logic [ssct_pkg::ENT_W-1:0]        clr_r, clr_nxt;
  logic [ssct_pkg::OP_W-1:0]         op_r, op_nxt;
  logic [ssct_pkg::ENT_W-1:0]        ent_r, ent_nxt;
  logic [ssct_pkg::ENT_W-1:0]        oth_r, oth_nxt;
  logic [ssct_pkg::DATA_WIDTH-1:0]   wdata_r, wdata_nxt;
  logic [ssct_pkg::SLOT_W-1:0]       s_r, s_nxt;
  logic [ssct_pkg::COUNT_W-1:0]      count_r, count_nxt;
  logic [ssct_pkg::STAT_W-1:0]       status_r, status_nxt;
  logic [ssct_pkg::DATA_WIDTH-1:0]   rdata_r, rdata_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [ssct_pkg::STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [ssct_pkg::DATA_WIDTH-1:0]   out_rdata_r, out_rdata_nxt;
  logic [ssct_pkg::COUNT_W-1:0]      out_count_r, out_count_nxt;

  logic                              accept;
  logic                              m_valid;
  logic [ssct_pkg::SLOT_W-1:0]       m_slot;
  logic                              present;
  logic                              ent_ok;
  logic                              oth_ok;
  logic [ssct_pkg::COUNT_W-1:0]      cnt_dec;
  logic [ssct_pkg::SLOT_W-1:0]       last_slot;
  logic [ssct_pkg::SLOT_W-1:0]       top_slot;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;

  // Decode the map word read for the current lookup
  assign m_valid   = map_rdata[ssct_pkg::SLOT_W];
  assign m_slot    = map_rdata[ssct_pkg::SLOT_W-1:0];
  assign present   = m_valid && ({1'b0, m_slot} < count_r);
  assign ent_ok    = (ent_r < ENT_LAST);
  assign oth_ok    = (oth_r < ENT_LAST);
  assign cnt_dec   = count_r - ssct_pkg::COUNT_W'(1);
  assign last_slot = cnt_dec[ssct_pkg::SLOT_W-1:0];
  assign top_slot  = count_r[ssct_pkg::SLOT_W-1:0];

  // Sequence one item through the memories
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    op_nxt     = op_r;
    ent_nxt    = ent_r;
    oth_nxt    = oth_r;
    wdata_nxt  = wdata_r;
    s_nxt      = s_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    rdata_nxt  = rdata_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_rdata_nxt  = out_rdata_r;
    out_count_nxt  = out_count_r;
    mem_req = '0;
    mem_req.map_raddr = ent_r;
    case (state_r)
      S_CLEAR: begin
        // Mark one map entry absent per cycle
        mem_req.map_we    = 1'b1;
        mem_req.map_waddr = clr_r;
        if (clr_r == ENT_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + ssct_pkg::ENT_W'(1);
        end
      end
      S_IDLE: begin
        mem_req.map_raddr = in_entity;
        if (accept) begin
          op_nxt    = in_op;
          ent_nxt   = in_entity;
          oth_nxt   = in_other_entity;
          wdata_nxt = in_write_data;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        s_nxt      = m_slot;
        status_nxt = ssct_pkg::ST_OK;
        rdata_nxt  = '0;
        state_nxt  = S_RESP;
        case (op_r)
          ssct_pkg::OP_GET: begin
            if (!ent_ok) begin
              status_nxt = ssct_pkg::ST_INVALID;
            end else if (!present) begin
              status_nxt = ssct_pkg::ST_ABSENT;
            end else begin
              mem_req.data_raddr = m_slot;
              state_nxt          = S_READ;
            end
          end
          ssct_pkg::OP_SET: begin
            if (!ent_ok) begin
              status_nxt = ssct_pkg::ST_INVALID;
            end else if (!present) begin
              status_nxt = ssct_pkg::ST_ABSENT;
            end else begin
              mem_req.data_we    = 1'b1;
              mem_req.data_waddr = m_slot;
              mem_req.data_wdata = wdata_r;
            end
          end
          ssct_pkg::OP_ADD: begin
            if (!ent_ok) begin
              status_nxt = ssct_pkg::ST_INVALID;
            end else if (!present) begin
              if (count_r == CNT_FULL) begin
                status_nxt = ssct_pkg::ST_FULL;
              end else begin
                // Append a zeroed slot and point the map at it
                mem_req.data_we    = 1'b1;
                mem_req.data_waddr = top_slot;
                mem_req.own_we     = 1'b1;
                mem_req.own_waddr  = top_slot;
                mem_req.own_wdata  = ent_r;
                mem_req.map_we     = 1'b1;
                mem_req.map_waddr  = ent_r;
                mem_req.map_wdata  = {1'b1, top_slot};
                count_nxt          = count_r + ssct_pkg::COUNT_W'(1);
              end
            end
          end
          ssct_pkg::OP_COPY: begin
            if (!ent_ok || !oth_ok) begin
              status_nxt = ssct_pkg::ST_INVALID;
            end else if (!present) begin
              status_nxt = ssct_pkg::ST_ABSENT;
            end else begin
              // Fetch source data and target map entry together
              mem_req.map_raddr  = oth_r;
              mem_req.data_raddr = m_slot;
              state_nxt          = S_LOOK2;
            end
          end
          ssct_pkg::OP_DEL: begin
            if (!ent_ok) begin
              status_nxt = ssct_pkg::ST_INVALID;
            end else if (present) begin
              mem_req.data_raddr = last_slot;
              mem_req.own_raddr  = last_slot;
              state_nxt          = S_DEL;
            end
          end
          default: begin
            status_nxt = ssct_pkg::ST_OK;
          end
        endcase
      end
      S_LOOK2: begin
        if (!present) begin
          status_nxt = ssct_pkg::ST_ABSENT;
        end else begin
          mem_req.data_we    = 1'b1;
          mem_req.data_waddr = m_slot;
          mem_req.data_wdata = data_rdata;
        end
        state_nxt = S_RESP;
      end
      S_READ: begin
        rdata_nxt = data_rdata;
        state_nxt = S_RESP;
      end
      S_DEL: begin
        // Move the last entry into the hole and repoint its owner
        if (s_r != last_slot) begin
          mem_req.data_we    = 1'b1;
          mem_req.data_waddr = s_r;
          mem_req.data_wdata = data_rdata;
          mem_req.own_we     = 1'b1;
          mem_req.own_waddr  = s_r;
          mem_req.own_wdata  = own_rdata;
          mem_req.map_we     = 1'b1;
          mem_req.map_waddr  = own_rdata;
          mem_req.map_wdata  = {1'b1, s_r};
        end
        state_nxt = S_DEL2;
      end
      S_DEL2: begin
        // Drop the deleted entity and pop the last slot
        mem_req.map_we    = 1'b1;
        mem_req.map_waddr = ent_r;
        count_nxt         = cnt_dec;
        state_nxt         = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_rdata_nxt  = rdata_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    ent_r        <= ent_nxt;
    oth_r        <= oth_nxt;
    wdata_r      <= wdata_nxt;
    s_r          <= s_nxt;
    status_r     <= status_nxt;
    rdata_r      <= rdata_nxt;
    out_status_r <= out_status_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_data  = out_rdata_r;
  assign out_live_count = out_count_r;
  assign stat.clearing  = (state_r == S_CLEAR);
  assign stat.busy      = (state_r != S_IDLE);

endmodule

/* rtl/sparse_set_component_table_unit.sv */
// Top level of the sparse set component table: stream ports, memories, checks.
//
// Sparse set keyed by entity id with swap-remove delete. Items are handled one
// at a time; each yields one result. Every item takes a first map lookup; a get
// of a present entity then reads its data word, a copy whose source is present
// then looks up the target while reading the source data and writes it, and a
// delete of a present entity reads the last slot, moves it into the hole and
// then drops the entity. The map, data and owner memories each have a
// registered read and are used in sequence. A finished result waits in an output
// register, so the next item can be taken while it waits. After reset a clearing
// pass marks all 1024 map entries (ENTITY_SPACE) absent, one per cycle; no item
// is accepted during it.
`include "sparse_set_component_table_unit_defines.svh"

module sparse_set_component_table_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // op, entity, other_entity, write_data, zero fill
  input  logic [ssct_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status, read_data, live_count, zero fill
  output logic [ssct_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam logic [ssct_pkg::COUNT_W-1:0] CNT_CAP =
    ssct_pkg::COUNT_W'(ssct_pkg::CAPACITY);

  ssct_pkg::mem_req_t                  mem_req;
  ssct_pkg::ctrl_stat_t                ctrl_stat;
  logic [ssct_pkg::MAP_W-1:0]          map_rdata;
  logic [ssct_pkg::DATA_WIDTH-1:0]     data_rdata;
  logic [ssct_pkg::ENT_W-1:0]          own_rdata;
  logic [ssct_pkg::STAT_W-1:0]         out_status;
  logic [ssct_pkg::DATA_WIDTH-1:0]     out_read_data;
  logic [ssct_pkg::COUNT_W-1:0]        out_live_count;
  logic                                in_accept;
  logic                                out_full;

  // Sequencer
  ssct_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_op           (in_tdata[ssct_pkg::OP_W-1:0]),
    .in_entity       (in_tdata[ssct_pkg::IN_ENT_LSB +: ssct_pkg::ENT_W]),
    .in_other_entity (in_tdata[ssct_pkg::IN_OTH_LSB +: ssct_pkg::ENT_W]),
    .in_write_data   (in_tdata[ssct_pkg::IN_DAT_LSB +: ssct_pkg::DATA_WIDTH]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (out_status),
    .out_read_data   (out_read_data),
    .out_live_count  (out_live_count),
    .mem_req         (mem_req),
    .map_rdata       (map_rdata),
    .data_rdata      (data_rdata),
    .own_rdata       (own_rdata),
    .stat            (ctrl_stat)
  );

  // Sparse map: entity to {valid, slot}
  ssct_ram #(
    .WIDTH (ssct_pkg::MAP_W),
    .DEPTH (ssct_pkg::ENTITY_SPACE)
  ) u_map (
    .clk   (clk),
    .we    (mem_req.map_we),
    .waddr (mem_req.map_waddr),
    .wdata (mem_req.map_wdata),
    .raddr (mem_req.map_raddr),
    .rdata (map_rdata)
  );

  // Dense data words
  ssct_ram #(
    .WIDTH (ssct_pkg::DATA_WIDTH),
    .DEPTH (ssct_pkg::CAPACITY)
  ) u_data (
    .clk   (clk),
    .we    (mem_req.data_we),
    .waddr (mem_req.data_waddr),
    .wdata (mem_req.data_wdata),
    .raddr (mem_req.data_raddr),
    .rdata (data_rdata)
  );

  // Dense owner ids
  ssct_ram #(
    .WIDTH (ssct_pkg::ENT_W),
    .DEPTH (ssct_pkg::CAPACITY)
  ) u_owner (
    .clk   (clk),
    .we    (mem_req.own_we),
    .waddr (mem_req.own_waddr),
    .wdata (mem_req.own_wdata),
    .raddr (mem_req.own_raddr),
    .rdata (own_rdata)
  );

  // Pack the result item
  assign out_tdata = ssct_pkg::OUT_TDATA_W'({out_live_count, out_read_data, out_status});

  // Flag accepted items and full results for the checks
  assign in_accept = in_tvalid && in_tready;
  assign out_full  = out_tvalid && (out_status == ssct_pkg::ST_FULL);

  // Checks
  `SSCT_ASSERT_IMP(a_no_accept_in_clear, ctrl_stat.clearing, !in_tready, "ready in clear")
  `SSCT_ASSERT_NEXT(a_one_item_at_a_time, in_accept, ctrl_stat.busy, "idle after accept")
  `SSCT_ASSERT_IMP(a_count_bound, out_tvalid, out_live_count <= CNT_CAP, "count over capacity")
  `SSCT_ASSERT_IMP(a_full_at_capacity, out_full, out_live_count == CNT_CAP, "full below capacity")

endmodule
